>>> rtl/hcs_pkg.sv
package hcs_pkg;

  // nesting counter width, counter saturates at all ones
  localparam int unsigned DepthBits = 8;

  localparam logic [7:0] ChOpen   = 8'h28;
  localparam logic [7:0] ChClose  = 8'h29;
  localparam logic [7:0] ChBslash = 8'h5c;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_present;
    logic       final_item;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_present;
    logic       run_last;
    logic       text_end;
  } out_item_t;

  // one queued result byte
  typedef struct packed {
    logic [7:0] data;
    logic       present;
  } res_entry_t;

  // c-locale whitespace: tab, lf, vt, ff, cr, space
  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

endpackage

>>> rtl/hcs_in_if.sv
interface hcs_in_if;
  import hcs_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/hcs_out_if.sv
interface hcs_out_if;
  import hcs_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/header_comment_stripper.sv
// Header comment stripper: removes nested parenthesized comments from a
// mail header value and collapses whitespace runs.
// in_ch_i carries one transaction per byte (text_byte, byte_present,
// final_item); final_item closes the value, byte_present 0 with final_item
// 1 is a bare end marker. out_ch_o carries result bytes; run_last marks the
// last result of an input transaction, text_end the end of the value, and
// out_present 0 marks an empty value.
// An input transaction is decoded in the cycle it is accepted and its
// results (up to three) land in a three-entry result queue; the first
// result is visible in the cycle after acceptance.
// Throughput is one input byte per cycle while each byte causes at most
// one result and the receiver is ready; a byte that releases withheld
// whitespace causes up to three results, and the queue drains them one
// per cycle while the receiver is ready. A new input is taken whenever
// the queue is empty or its last entry leaves in the same cycle.
// If the receiver stalls, the queue holds its entries and the input side
// stops once the queue cannot take the next transaction.
// Reset clears nesting depth, escape flag, whitespace hold count and the
// result queue; the block accepts input right after reset.
module header_comment_stripper (
  input  logic       clk_i,
  input  logic       rst_ni,
  hcs_in_if.sink     in_ch_i,
  hcs_out_if.source  out_ch_o
);
  import hcs_pkg::*;

  localparam logic [DepthBits-1:0] DepthMax = '1;

  // decoder state
  logic [DepthBits-1:0] depth_q, depth_d;
  logic                 esc_q, esc_d;
  logic                 lws_q, lws_d;
  logic [1:0]           held_cnt_q, held_cnt_d;
  logic [7:0]           held_q [2];
  logic [7:0]           held_d [2];

  // result queue
  res_entry_t buf_q [3];
  res_entry_t res   [3];
  logic [1:0] cnt_q;
  logic       end_q;
  logic [1:0] n;

  logic       in_acc, out_acc;
  logic       do_flush, do_hold;
  logic [7:0] b;
  logic       ws;

  assign in_ch_i.ready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ch_o.ready);
  assign in_acc  = in_ch_i.valid && in_ch_i.ready;
  assign out_acc = out_ch_o.valid && out_ch_o.ready;
  assign b  = in_ch_i.data.text_byte;
  assign ws = is_ws(b);

  // byte classification and state update
  always_comb begin
    depth_d    = depth_q;
    esc_d      = esc_q;
    lws_d      = lws_q;
    held_cnt_d = held_cnt_q;
    held_d     = held_q;
    do_flush   = 1'b0;
    do_hold    = 1'b0;
    n          = 2'd0;
    for (int i = 0; i < 3; i++) begin
      res[i] = '{data: 8'h00, present: 1'b1};
    end

    if (in_ch_i.data.byte_present) begin
      if (esc_q) begin
        esc_d = 1'b0;
        if (depth_q == '0) begin
          if (ws) do_hold = 1'b1;
          else    do_flush = 1'b1;
          lws_d = 1'b0;
        end
      end else if (b == ChOpen) begin
        if (depth_q != DepthMax) depth_d = depth_q + 1'b1;
      end else if (b == ChClose) begin
        if (depth_q != '0) depth_d = depth_q - 1'b1;
      end else if (b == ChBslash) begin
        if (depth_q == '0) begin
          do_flush = 1'b1;
          lws_d    = 1'b0;
        end
        esc_d = 1'b1;
      end else if (depth_q == '0) begin
        if (!ws) begin
          do_flush = 1'b1;
          lws_d    = 1'b0;
        end else if (!lws_q) begin
          do_hold = 1'b1;
          lws_d   = 1'b1;
        end
      end
    end

    // release withheld whitespace ahead of the byte
    if (do_flush) begin
      case (held_cnt_q)
        2'd0: begin
          res[0].data = b;
          n = 2'd1;
        end
        2'd1: begin
          res[0].data = held_q[0];
          res[1].data = b;
          n = 2'd2;
        end
        default: begin
          res[0].data = held_q[0];
          res[1].data = held_q[1];
          res[2].data = b;
          n = 2'd3;
        end
      endcase
      held_cnt_d = 2'd0;
    end

    // withhold whitespace, full store pushes out the oldest byte
    if (do_hold) begin
      case (held_cnt_q)
        2'd0: begin
          held_d[0]  = b;
          held_cnt_d = 2'd1;
        end
        2'd1: begin
          held_d[1]  = b;
          held_cnt_d = 2'd2;
        end
        default: begin
          res[0].data = held_q[0];
          n           = 2'd1;
          held_d[0]   = held_q[1];
          held_d[1]   = b;
          held_cnt_d  = 2'd2;
        end
      endcase
    end

    // end of value: empty result if nothing else, then back to reset state
    if (in_ch_i.data.final_item) begin
      if (n == 2'd0) begin
        res[0] = '{data: 8'h00, present: 1'b0};
        n      = 2'd1;
      end
      depth_d    = '0;
      esc_d      = 1'b0;
      lws_d      = 1'b1;
      held_cnt_d = 2'd0;
    end
  end

  // decoder control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q    <= '0;
      esc_q      <= 1'b0;
      lws_q      <= 1'b1;
      held_cnt_q <= 2'd0;
    end else if (in_acc) begin
      depth_q    <= depth_d;
      esc_q      <= esc_d;
      lws_q      <= lws_d;
      held_cnt_q <= held_cnt_d;
    end
  end

  // withheld whitespace bytes
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      held_q <= held_d;
    end
  end

  // queue occupancy and end flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      end_q <= 1'b0;
    end else if (in_acc && (n != 2'd0)) begin
      cnt_q <= n;
      end_q <= in_ch_i.data.final_item;
    end else if (out_acc) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // queue entries, shift toward the head on each output transaction
  always_ff @(posedge clk_i) begin
    if (in_acc && (n != 2'd0)) begin
      buf_q <= res;
    end else if (out_acc) begin
      buf_q[0] <= buf_q[1];
      buf_q[1] <= buf_q[2];
    end
  end

  // output channel
  assign out_ch_o.valid            = (cnt_q != 2'd0);
  assign out_ch_o.data.out_byte    = buf_q[0].data;
  assign out_ch_o.data.out_present = buf_q[0].present;
  assign out_ch_o.data.run_last    = (cnt_q == 2'd1);
  assign out_ch_o.data.text_end    = end_q && (cnt_q == 2'd1);

  // end of value leaves the decoder in its reset state
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_ch_i.data.final_item |=>
      (depth_q == '0) && !esc_q && lws_q && (held_cnt_q == 2'd0))
    else $error("decoder state not cleared after end of value");

  // hold store never overfills
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_cnt_q != 2'd3)
    else $error("whitespace hold count out of range");

  // draining the last entry without new input empties the queue
  a_drain_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && (cnt_q == 2'd1) && !in_acc |=> (cnt_q == 2'd0))
    else $error("result queue not empty after last entry left");

  // an empty result only ever ends a value
  a_empty_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch_o.valid && !out_ch_o.data.out_present |->
      out_ch_o.data.text_end && (out_ch_o.data.out_byte == 8'h00))
    else $error("empty result outside end of value");

endmodule

>>> tb/tb_top.sv
module tb_top;
  import hcs_pkg::*;

  // whitespace bytes in the c locale
  localparam logic [7:0] WsBytes [6] = '{8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'h20};
  localparam int unsigned IdleLimit = 2000;

  // predicts stripped output bytes and checks them in order
  class strip_scoreboard;
    logic [DepthBits-1:0] depth;
    bit                   escaped;
    bit                   after_space;
    logic [7:0]           held [2];
    logic [1:0]           held_cnt;
    out_item_t            burst [$];
    out_item_t            want_q [$];
    int unsigned          errors;
    int unsigned          n_in;
    int unsigned          n_out;
    int unsigned          n_values;

    // start from the reset state of the block
    function new();
      clear_state();
    endfunction

    function void clear_state();
      depth       = '0;
      escaped     = 1'b0;
      after_space = 1'b1;
      held_cnt    = 2'd0;
    endfunction

    function bit is_space(logic [7:0] b);
      return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0d));
    endfunction

    function void emit(logic [7:0] b);
      burst.push_back('{out_byte: b, out_present: 1'b1, run_last: 1'b0, text_end: 1'b0});
    endfunction

    function void flush_held();
      for (int i = 0; i < held_cnt; i++) emit(held[i]);
      held_cnt = 2'd0;
    endfunction

    // withhold whitespace, oldest byte leaves if the store is full
    function void hold(logic [7:0] b);
      if (held_cnt >= 2'd2) begin
        emit(held[0]);
        held[0]  = held[1];
        held_cnt = 2'd1;
      end
      held[held_cnt[0]] = b;
      held_cnt++;
    endfunction

    // work out the results of one accepted input transaction
    function void note_input(in_item_t it);
      int unsigned last;
      burst.delete();
      n_in++;
      if (it.byte_present) begin
        if (escaped) begin
          escaped = 1'b0;
          if (depth == '0) begin
            if (is_space(it.text_byte)) begin
              hold(it.text_byte);
            end else begin
              flush_held();
              emit(it.text_byte);
            end
            after_space = 1'b0;
          end
        end else if (it.text_byte == ChOpen) begin
          if (depth != '1) depth++;
        end else if (it.text_byte == ChClose) begin
          if (depth != '0) depth--;
        end else if (it.text_byte == ChBslash) begin
          if (depth == '0) begin
            flush_held();
            emit(it.text_byte);
            after_space = 1'b0;
          end
          escaped = 1'b1;
        end else if (depth == '0) begin
          if (!is_space(it.text_byte)) begin
            flush_held();
            emit(it.text_byte);
            after_space = 1'b0;
          end else if (!after_space) begin
            hold(it.text_byte);
            after_space = 1'b1;
          end
        end
      end
      if (it.final_item) begin
        if (burst.size() == 0)
          burst.push_back('{out_byte: 8'h00, out_present: 1'b0, run_last: 1'b0,
                            text_end: 1'b0});
        last = burst.size() - 1;
        burst[last].text_end = 1'b1;
        clear_state();
        n_values++;
      end
      if (burst.size() > 0) begin
        last = burst.size() - 1;
        burst[last].run_last = 1'b1;
      end
      foreach (burst[i]) want_q.push_back(burst[i]);
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_result(out_item_t got);
      out_item_t want;
      n_out++;
      if (want_q.size() == 0) begin
        $error("unexpected result: out_byte %02h out_present %0b", got.out_byte,
               got.out_present);
        errors++;
        return;
      end
      want = want_q.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.out_present !== want.out_present) begin
        $error("out_present: expected %0b, got %0b", want.out_present, got.out_present);
        errors++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
        errors++;
      end
      if (got.text_end !== want.text_end) begin
        $error("text_end: expected %0b, got %0b", want.text_end, got.text_end);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   quiet_mode;

  strip_scoreboard sb = new;

  hcs_in_if  in_if ();
  hcs_out_if out_if ();

  header_comment_stripper i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_if),
    .out_ch_o (out_if)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // idle length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // monitor both channels and watch for a stuck block
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.note_input(in_if.data);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no transaction for %0d cycles", IdleLimit);
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver with random stalls
  initial begin : out_ready_drv
    int unsigned run_len;
    int unsigned stall_len;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      run_len   = $urandom_range(1, 16);
      stall_len = pick_gap();
      if (stall_len > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall_len) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat (run_len) @(posedge clk_i);
    end
  end

  // one input transaction, after an optional gap
  task automatic send_item(input logic [7:0] b, input logic present, input logic fin);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= '{text_byte: b, byte_present: present, final_item: fin};
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_text(input string s, input bit fin);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b1, fin && (i == s.len() - 1));
  endtask

  // random byte biased toward text, whitespace and the special characters
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + $urandom_range(0, 25));
    if (r < 55) return WsBytes[$urandom_range(0, 5)];
    if (r < 65) return ChOpen;
    if (r < 75) return ChClose;
    if (r < 83) return ChBslash;
    return 8'($urandom_range(0, 255));
  endfunction

  // stimulus
  initial begin
    int unsigned n_rand;
    int unsigned len;
    rst_ni       = 1'b0;
    quiet_mode   = 1'b0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty value, then a bare marker that must change nothing
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h5a, 1'b0, 1'b0);
    // escaped space plus a second space, released as a three byte burst
    send_text(" a\\ \tb", 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    // stray close, nested comment with an escaped close inside
    send_text(")(x(\\))y)z", 1'b0);
    send_item(8'h0b, 1'b1, 1'b0);
    send_item(8'h0c, 1'b1, 1'b0);
    send_item(8'h0d, 1'b1, 1'b0);
    send_item(8'h0a, 1'b1, 1'b0);
    // comment still open at the end, trailing whitespace dropped
    send_text("(o", 1'b1);
    // lone backslash at the end
    send_text("q\\", 1'b1);

    // depth saturation: one open too many must not wrap the counter
    quiet_mode = 1'b1;
    repeat (256) send_item(ChOpen, 1'b1, 1'b0);
    send_item("x", 1'b1, 1'b0);
    repeat (255) send_item(ChClose, 1'b1, 1'b0);
    send_item("y", 1'b1, 1'b1);
    quiet_mode = 1'b0;

    // random header values
    n_rand = 0;
    while (n_rand < 110) begin
      quiet_mode = ($urandom_range(0, 3) == 0);
      len = $urandom_range(1, 12);
      if ($urandom_range(0, 6) == 0) begin
        send_item("k", 1'b1, 1'b0);
        send_item(ChBslash, 1'b1, 1'b0);
        send_item(WsBytes[$urandom_range(0, 5)], 1'b1, 1'b0);
        send_item(WsBytes[$urandom_range(0, 5)], 1'b1, 1'b0);
        n_rand += 4;
      end
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 19) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        send_item(pick_byte(), 1'b1, (i == len - 1) && ($urandom_range(0, 4) != 0));
        n_rand++;
      end
      // most values end on their last byte, the rest on a bare end marker
      if (!in_if.data.final_item) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        n_rand++;
      end
    end
    quiet_mode = 1'b0;
    in_if.valid <= 1'b0;

    // drain, then keep watching for anything spurious
    while (sb.want_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("stripped %0d header values from %0d input transactions", sb.n_values,
             sb.n_in);
    $display("%0d result transactions checked, %0d mismatches", sb.n_out, sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/hcs_pkg.sv
rtl/hcs_in_if.sv
rtl/hcs_out_if.sv
rtl/header_comment_stripper.sv
tb/tb_top.sv
